// File: hdl/least_loaded_task_assigner_defines.svh
// ----------------------------------------------------------------------------
// least_loaded_task_assigner_defines
// Assertion macros for the least loaded task assigner.
// ----------------------------------------------------------------------------
`ifndef LEAST_LOADED_TASK_ASSIGNER_DEFINES_SVH
`define LEAST_LOADED_TASK_ASSIGNER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define LLTA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LLTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LLTA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define LLTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: hdl/llta_pkg.sv
// ----------------------------------------------------------------------------
// llta_pkg
// Types and constants shared by the least loaded task assigner modules.
// ----------------------------------------------------------------------------
`default_nettype none

package llta_pkg;

   localparam int MAX_PROC_DEFAULT = 16;
   localparam int LOAD_W           = 32;
   localparam int DUR_W            = 16;
   localparam int PROC_W           = 4;
   localparam int CNT_REG_W        = 5;
   localparam logic [CNT_REG_W-1:0] COUNT_RESET = 5'd16;

   typedef struct packed {
      logic [DUR_W-1:0] task_duration;
      logic             last_task;
   } llta_req_type;

   typedef struct packed {
      logic [PROC_W-1:0] assigned_processor;
      logic [LOAD_W-1:0] makespan;
      logic [PROC_W-1:0] busiest_processor;
      logic              job_done;
   } llta_rsp_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_ROOT  = 6'b000010,
      ST_SIFT  = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_FLUSH = 6'b010000,
      ST_EMIT  = 6'b100000
   } llta_state_type;

   typedef struct packed {
      logic start;
      logic root;
      logic sift;
      logic scan;
      logic emit;
      logic cfg_wr;
   } llta_cmd_type;

   typedef struct packed {
      logic sift_done;
      logic scan_last;
      logic last_task;
      logic rsp_free;
   } llta_status_type;

endpackage

`default_nettype wire

// File: hdl/llta_ctrl.sv
// ----------------------------------------------------------------------------
// llta_ctrl
// Sequencer: root update, sift-down levels, final scan and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module llta_ctrl import llta_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            csr_valid,
   input  wire llta_status_type status,
   output llta_cmd_type         cmd,
   output logic                 req_stall,
   output logic                 csr_ready
);

   llta_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.cfg_wr = csr_valid;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_ROOT;
            end
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
            state_in = ST_SIFT;
         end
         ST_SIFT: begin
            cmd.sift = 1'b1;
            if (status.sift_done) begin
               state_in = status.last_task ? ST_SCAN : ST_EMIT;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_last) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

endmodule

`default_nettype wire

// File: hdl/llta_datapath.sv
// ----------------------------------------------------------------------------
// llta_datapath
// Heap memory with two read ports, sift-down compare, max scan, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module llta_datapath import llta_pkg::*; #(
   parameter int MAX_PROCESSORS = MAX_PROC_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire llta_cmd_type         cmd,
   output llta_status_type           status,
   input  wire llta_req_type         req_data,
   input  wire logic [CNT_REG_W-1:0] csr_wdata,
   input  wire logic                 rsp_stall,
   output logic                      rsp_valid,
   output llta_rsp_type              rsp_data
);

   localparam int PW = $clog2(MAX_PROCESSORS);
   localparam int XW = PW + 2;
   localparam int CW = $clog2(MAX_PROCESSORS + 1);
   localparam logic [PW-1:0] ID_MASK = PW'(15);
   localparam logic [XW-1:0] DEPTH_X = XW'(MAX_PROCESSORS);

   // heap storage, entries without a valid flag read as reset contents
   logic [LOAD_W-1:0]         mem_load [MAX_PROCESSORS];
   logic [PW-1:0]             mem_id   [MAX_PROCESSORS];
   logic [MAX_PROCESSORS-1:0] vld_ff;

   logic              mem_we;
   logic [PW-1:0]     mem_waddr;
   logic [LOAD_W-1:0] mem_wload;
   logic [PW-1:0]     mem_wid;
   logic [PW-1:0]     ra_addr, rb_addr;

   logic [LOAD_W-1:0] ra_load_ff, rb_load_ff;
   logic [PW-1:0]     ra_id_ff, rb_id_ff;
   logic              ra_vld_ff, rb_vld_ff;
   logic [PW-1:0]     ra_pos_ff, rb_pos_ff;

   logic [CNT_REG_W-1:0] count_ff, count_in;
   logic [DUR_W-1:0]     dur_ff, dur_in;
   logic                 last_ff, last_in;
   logic [LOAD_W-1:0]    cur_load_ff, cur_load_in;
   logic [PW-1:0]        cur_id_ff, cur_id_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [PW-1:0]        asg_ff, asg_in;
   logic [LOAD_W-1:0]    mx_ff, mx_in;
   logic [PW-1:0]        bz_ff, bz_in;
   logic [CW-1:0]        sidx_ff, sidx_in;
   logic                 scan_pend_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   llta_rsp_type         rsp_ff, rsp_in;

   logic [LOAD_W-1:0] a_load, b_load, pick_load;
   logic [PW-1:0]     a_id, b_id, pick_id, pick_pos, child_base;
   logic [XW-1:0]     lpos, rpos, cl_pos, cr_pos, cnt_x;
   logic [CW-1:0]     cnt;
   logic [LOAD_W:0]   sum;
   logic              has_l, has_r, take_r, go_down;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_load[mem_waddr] <= mem_wload;
         mem_id[mem_waddr]   <= mem_wid;
      end
      ra_load_ff <= mem_load[ra_addr];
      ra_id_ff   <= mem_id[ra_addr];
      ra_vld_ff  <= vld_ff[ra_addr];
      ra_pos_ff  <= ra_addr;
      rb_load_ff <= mem_load[rb_addr];
      rb_id_ff   <= mem_id[rb_addr];
      rb_vld_ff  <= vld_ff[rb_addr];
      rb_pos_ff  <= rb_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.cfg_wr || (cmd.emit && last_ff)) begin
         vld_ff <= '0;
      end else if (mem_we) begin
         vld_ff[mem_waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         scan_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         scan_pend_ff <= cmd.scan;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dur_ff      <= dur_in;
      last_ff     <= last_in;
      cur_load_ff <= cur_load_in;
      cur_id_ff   <= cur_id_in;
      pos_ff      <= pos_in;
      asg_ff      <= asg_in;
      mx_ff       <= mx_in;
      bz_ff       <= bz_in;
      sidx_ff     <= sidx_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      if (count_ff == '0) begin
         cnt = CW'(1);
      end else if (32'(count_ff) > MAX_PROCESSORS) begin
         cnt = CW'(MAX_PROCESSORS);
      end else begin
         cnt = CW'(count_ff);
      end
      cnt_x = XW'(cnt);

      a_load = ra_vld_ff ? ra_load_ff : '0;
      a_id   = ra_vld_ff ? ra_id_ff : (ra_pos_ff & ID_MASK);
      b_load = rb_vld_ff ? rb_load_ff : '0;
      b_id   = rb_vld_ff ? rb_id_ff : (rb_pos_ff & ID_MASK);

      // children of the sifting position, left wins ties
      lpos      = {1'b0, pos_ff, 1'b1};
      rpos      = {1'b0, pos_ff, 1'b0} + XW'(2);
      has_l     = (lpos < cnt_x);
      has_r     = (rpos < cnt_x);
      take_r    = has_r && (b_load < a_load);
      pick_load = take_r ? b_load : a_load;
      pick_id   = take_r ? b_id : a_id;
      pick_pos  = take_r ? rpos[PW-1:0] : lpos[PW-1:0];
      go_down   = has_l && (cur_load_ff > pick_load);

      mem_we    = cmd.sift;
      mem_waddr = pos_ff;
      mem_wload = go_down ? pick_load : cur_load_ff;
      mem_wid   = go_down ? pick_id : cur_id_ff;

      child_base = cmd.sift ? pick_pos : '0;
      cl_pos     = {1'b0, child_base, 1'b1};
      cr_pos     = {1'b0, child_base, 1'b0} + XW'(2);
      ra_addr    = (cl_pos < DEPTH_X) ? cl_pos[PW-1:0] : '0;
      rb_addr    = (cr_pos < DEPTH_X) ? cr_pos[PW-1:0] : '0;
      if (cmd.start) begin
         ra_addr = '0;
      end else if (cmd.scan) begin
         ra_addr = sidx_ff[PW-1:0];
      end

      sum = {1'b0, a_load} + (LOAD_W + 1)'(dur_ff);

      count_in    = cmd.cfg_wr ? csr_wdata : count_ff;
      dur_in      = cmd.start ? req_data.task_duration : dur_ff;
      last_in     = cmd.start ? req_data.last_task : last_ff;
      cur_load_in = cur_load_ff;
      cur_id_in   = cur_id_ff;
      pos_in      = pos_ff;
      asg_in      = asg_ff;
      mx_in       = mx_ff;
      bz_in       = bz_ff;
      sidx_in     = sidx_ff;

      if (cmd.root) begin
         cur_load_in = sum[LOAD_W] ? '1 : sum[LOAD_W-1:0];
         cur_id_in   = a_id;
         pos_in      = '0;
         asg_in      = a_id;
         mx_in       = '0;
         bz_in       = '0;
         sidx_in     = '0;
      end
      if (cmd.sift && go_down) begin
         pos_in = pick_pos;
      end
      if (cmd.scan) begin
         sidx_in = sidx_ff + CW'(1);
      end
      if (scan_pend_ff && (a_load > mx_ff)) begin
         mx_in = a_load;
         bz_in = a_id;
      end

      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_in.assigned_processor = PROC_W'(asg_ff);
         rsp_in.makespan           = mx_ff;
         rsp_in.busiest_processor  = PROC_W'(bz_ff);
         rsp_in.job_done           = last_ff;
         rsp_valid_in              = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      status.sift_done = !go_down;
      status.scan_last = (sidx_ff == (cnt - CW'(1)));
      status.last_task = last_ff;
      status.rsp_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// File: hdl/least_loaded_task_assigner.sv
// ----------------------------------------------------------------------------
// least_loaded_task_assigner
// Greedy list scheduler: each task goes to the least loaded processor.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one task per transaction (duration, last-task flag), valid/stall.
//   rsp_*  : one result per task (processor, makespan, busiest, job_done).
//   csr_*  : processor count write; clears the heap and starts a new job.
// Sequence: the root entry is read and its load raised by the task duration,
//   then the sift-down runs 1 .. floor(log2(count)) + 1 steps (at most 5 for
//   16), one heap level per cycle through the two-read-port heap memory; on
//   the last task of a job a max scan over all processors follows. A new
//   task is taken the cycle after the result is loaded.
// Reset: processor count 16, heap empty (loads zero, ids in order) through
//   per-entry valid flags, no clearing pass.
// Stall: a result held by rsp_stall stays in the output register; the next
//   task is still accepted and processed, then waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

`include "least_loaded_task_assigner_defines.svh"

module least_loaded_task_assigner import llta_pkg::*; #(
   parameter int MAX_PROCESSORS = MAX_PROC_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire llta_req_type         req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output llta_rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CNT_REG_W-1:0] csr_wdata
);

   llta_cmd_type    cmd;
   llta_status_type status;

   llta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .csr_valid (csr_valid),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall),
      .csr_ready (csr_ready)
   );

   llta_datapath #(
      .MAX_PROCESSORS (MAX_PROCESSORS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_wdata (csr_wdata),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `LLTA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall,
                     req_stall, "accept did not start processing")
   `LLTA_ASSERT_NEXT(a_emit_sets_valid, clock, reset, cmd.emit, rsp_valid,
                     "result not presented after emit")
   `LLTA_ASSERT_IMPLY(a_cmd_onehot, clock, reset, 1'b1,
                      $onehot0({cmd.start, cmd.root, cmd.sift, cmd.scan, cmd.emit}),
                      "conflicting commands")
   `LLTA_ASSERT_IMPLY(a_cfg_when_idle, clock, reset, csr_valid && csr_ready, !req_stall,
                      "register write while busy")

endmodule

`default_nettype wire
